// ----- hw/rtl/srtf_pkg.sv -----
// shared types and constants for the srtf scheduler
package srtf_pkg;

    localparam int MAX_SLOTS_DEF = 16;
    localparam int TIME_BITS_DEF = 16;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [19:0] SUM_MAX   = 20'hFFFFF;
    localparam logic [4:0]  COUNT_MAX = 5'd31;

    typedef struct packed {
        logic        kind;
        logic [3:0]  slot;
        logic [15:0] arrival;
        logic [15:0] burst;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  running_slot;
        logic        idle;
        logic        finished;
        logic [15:0] wait_ticks;
        logic [15:0] turnaround_time;
        logic [19:0] total_waiting;
        logic [19:0] total_turnaround;
        logic        all_done;
        logic [15:0] now;
    } t_out_item;

    typedef struct packed {
        logic we_all;
        logic we_rem;
    } t_mem_wr;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_SERVE,
        ST_FINISH,
        ST_ACCUM,
        ST_EMIT
    } t_state;

endpackage

// ----- hw/rtl/srtf_slot_mem.sv -----
// per-slot storage: remaining time, arrival time and burst length
module srtf_slot_mem #(
    parameter int MAX_SLOTS = srtf_pkg::MAX_SLOTS_DEF,
    parameter int TIME_BITS = srtf_pkg::TIME_BITS_DEF
) (
    input  logic                         i_clk,
    input  srtf_pkg::t_mem_wr            i_wr_ctl,
    input  logic [$clog2(MAX_SLOTS)-1:0] i_wr_addr,
    input  logic [15:0]                  i_wr_rem,
    input  logic [TIME_BITS-1:0]         i_wr_arr,
    input  logic [15:0]                  i_wr_need,
    input  logic [$clog2(MAX_SLOTS)-1:0] i_rd_addr,
    output logic [15:0]                  o_rd_rem,
    output logic [TIME_BITS-1:0]         o_rd_arr,
    output logic [15:0]                  o_rd_need
);
    import srtf_pkg::*;

    logic [15:0]          r_rem_mem  [MAX_SLOTS];
    logic [TIME_BITS-1:0] r_arr_mem  [MAX_SLOTS];
    logic [15:0]          r_need_mem [MAX_SLOTS];

    logic [15:0]          r_rd_rem;
    logic [TIME_BITS-1:0] r_rd_arr;
    logic [15:0]          r_rd_need;

    always_ff @(posedge i_clk) begin
        if (i_wr_ctl.we_all) begin
            r_rem_mem[i_wr_addr]  <= i_wr_rem;
            r_arr_mem[i_wr_addr]  <= i_wr_arr;
            r_need_mem[i_wr_addr] <= i_wr_need;
        end else if (i_wr_ctl.we_rem) begin
            r_rem_mem[i_wr_addr] <= i_wr_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_rem  <= r_rem_mem[i_rd_addr];
        r_rd_arr  <= r_arr_mem[i_rd_addr];
        r_rd_need <= r_need_mem[i_rd_addr];
    end

    assign o_rd_rem  = r_rd_rem;
    assign o_rd_arr  = r_rd_arr;
    assign o_rd_need = r_rd_need;

endmodule

// ----- hw/rtl/srtf_scheduler_top.sv -----
// shortest-remaining-time-first scheduler, top level
//
// input channel (i_in_valid / o_in_ready) takes one item: a load writes one
// slot's arrival time and burst, a tick serves one unit of work to the ready
// slot with the least remaining time (lowest slot on ties) and advances time.
// output channel (o_out_valid / i_out_ready) gives exactly one result item
// per input item, in order. i_cfg_we / i_cfg_data set process_count.
// a tick walks the slot store one entry per cycle through a single read port
// and one shared compare unit; when a slot finishes, the tick also passes
// through the finish and accumulate states before its result is emitted.
// the block is ready for the next item in the cycle after the result is
// loaded into the output register.
// the output register holds a result while the receiver stalls; the block
// keeps working on the next item and waits only when its own result is ready
// and the output register is still full.
// synchronous reset clears all slots to unloaded, time and totals to zero and
// process_count to zero; no clearing pass is needed.
module srtf_scheduler_top #(
    parameter int MAX_SLOTS = srtf_pkg::MAX_SLOTS_DEF,
    parameter int TIME_BITS = srtf_pkg::TIME_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  srtf_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output srtf_pkg::t_out_item o_out_item,
    input  logic                i_cfg_we,
    input  logic [4:0]          i_cfg_data
);
    import srtf_pkg::*;

    localparam int SLOT_W = $clog2(MAX_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_SLOTS - 1);

    function automatic logic [19:0] sat_add(input logic [19:0] acc, input logic [15:0] v);
        logic [20:0] s;
        s = {1'b0, acc} + {5'd0, v};
        return s[20] ? SUM_MAX : s[19:0];
    endfunction

    t_state r_state, n_state;

    t_in_item              r_item;
    logic [SLOT_W-1:0]     r_idx;
    logic [SLOT_W-1:0]     r_cmp_idx;
    logic                  r_cmp_vld;
    logic                  r_found;
    logic [SLOT_W-1:0]     r_best_idx;
    logic [15:0]           r_best_rem;
    logic [TIME_BITS-1:0]  r_best_arr;
    logic [15:0]           r_best_need;
    logic                  r_fin;
    logic [TIME_BITS-1:0]  r_turn;
    logic [TIME_BITS-1:0]  r_wait;
    logic [TIME_BITS-1:0]  r_time;
    logic [4:0]            r_done_cnt;
    logic [19:0]           r_sum_wait;
    logic [19:0]           r_sum_turn;
    logic [4:0]            r_proc_cnt;
    logic [MAX_SLOTS-1:0]  r_loaded;
    logic                  r_out_valid;
    t_out_item             r_out_item;

    logic c_in_ready, c_load, c_scan, c_serve, c_finish, c_accum, c_emit;
    logic accept, out_free, slot_ok, cand_ok, take;

    t_mem_wr              mem_wr;
    logic [SLOT_W-1:0]    mem_wr_addr;
    logic [15:0]          mem_wr_rem;
    logic [15:0]          rd_rem;
    logic [TIME_BITS-1:0] rd_arr;
    logic [15:0]          rd_need;
    t_out_item            res;

    assign accept   = c_in_ready && i_in_valid;
    assign out_free = !r_out_valid || i_out_ready;
    assign slot_ok  = 32'(r_item.slot) < 32'(MAX_SLOTS);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_in_valid) begin
                n_state = (i_in_item.kind == KIND_LOAD) ? ST_LOAD : ST_SCAN;
            end
            ST_LOAD:   n_state = ST_EMIT;
            ST_SCAN:   if (r_idx == LAST_SLOT) begin
                n_state = ST_DRAIN;
            end
            ST_DRAIN:  n_state = ST_SERVE;
            ST_SERVE:  n_state = (r_found && r_best_rem == 16'd1) ? ST_FINISH : ST_EMIT;
            ST_FINISH: n_state = ST_ACCUM;
            ST_ACCUM:  n_state = ST_EMIT;
            ST_EMIT:   if (out_free) begin
                n_state = ST_IDLE;
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        c_in_ready = 1'b0;
        c_load     = 1'b0;
        c_scan     = 1'b0;
        c_serve    = 1'b0;
        c_finish   = 1'b0;
        c_accum    = 1'b0;
        c_emit     = 1'b0;
        unique case (r_state)
            ST_IDLE:   c_in_ready = 1'b1;
            ST_LOAD:   c_load     = 1'b1;
            ST_SCAN:   c_scan     = 1'b1;
            ST_DRAIN:  c_scan     = 1'b0;
            ST_SERVE:  c_serve    = 1'b1;
            ST_FINISH: c_finish   = 1'b1;
            ST_ACCUM:  c_accum    = 1'b1;
            ST_EMIT:   c_emit     = 1'b1;
            default:   c_in_ready = 1'b0;
        endcase
    end

    // slot store access
    assign mem_wr.we_all = c_load && slot_ok;
    assign mem_wr.we_rem = c_serve && r_found;
    assign mem_wr_addr   = c_load ? SLOT_W'(r_item.slot) : r_best_idx;
    assign mem_wr_rem    = c_load ? r_item.burst : r_best_rem - 16'd1;

    srtf_slot_mem #(
        .MAX_SLOTS (MAX_SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_slot_mem (
        .i_clk     (i_clk),
        .i_wr_ctl  (mem_wr),
        .i_wr_addr (mem_wr_addr),
        .i_wr_rem  (mem_wr_rem),
        .i_wr_arr  (TIME_BITS'(r_item.arrival)),
        .i_wr_need (r_item.burst),
        .i_rd_addr (r_idx),
        .o_rd_rem  (rd_rem),
        .o_rd_arr  (rd_arr),
        .o_rd_need (rd_need)
    );

    // shared compare unit, one slot per cycle
    assign cand_ok = r_cmp_vld && r_loaded[r_cmp_idx] && (rd_rem != 16'd0) && (rd_arr <= r_time);
    assign take    = cand_ok && (!r_found || rd_rem < r_best_rem);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_cmp_vld   <= 1'b0;
            r_found     <= 1'b0;
            r_fin       <= 1'b0;
            r_time      <= '0;
            r_done_cnt  <= '0;
            r_sum_wait  <= '0;
            r_sum_turn  <= '0;
            r_proc_cnt  <= '0;
            r_loaded    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= c_scan;
            if (i_cfg_we) begin
                r_proc_cnt <= i_cfg_data;
            end
            if (accept) begin
                r_idx   <= '0;
                r_found <= 1'b0;
                r_fin   <= 1'b0;
            end else if (c_scan && r_idx != LAST_SLOT) begin
                r_idx <= r_idx + SLOT_W'(1);
            end
            if (take) begin
                r_found <= 1'b1;
            end
            if (c_load && slot_ok) begin
                r_loaded[SLOT_W'(r_item.slot)] <= 1'b1;
            end
            if (c_serve) begin
                r_time <= r_time + TIME_BITS'(1);
                r_fin  <= r_found && (r_best_rem == 16'd1);
            end
            if (c_finish) begin
                r_sum_turn <= sat_add(r_sum_turn, 16'(32'(r_turn)));
            end
            if (c_accum) begin
                r_sum_wait <= sat_add(r_sum_wait, 16'(32'(r_wait)));
                if (r_done_cnt != COUNT_MAX) begin
                    r_done_cnt <= r_done_cnt + 5'd1;
                end
            end
            if (c_emit && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in_item;
        end
        r_cmp_idx <= r_idx;
        if (take) begin
            r_best_idx  <= r_cmp_idx;
            r_best_rem  <= rd_rem;
            r_best_arr  <= rd_arr;
            r_best_need <= rd_need;
        end
        // finish time is the counter after this tick
        if (c_serve) begin
            r_turn <= r_time + TIME_BITS'(1) - r_best_arr;
        end
        if (c_finish) begin
            r_wait <= r_turn - TIME_BITS'(r_best_need);
        end
        if (c_emit && out_free) begin
            r_out_item <= res;
        end
    end

    always_comb begin
        res.running_slot     = r_found ? 4'(r_best_idx) : 4'd0;
        res.idle             = !r_found;
        res.finished         = r_fin;
        res.wait_ticks       = r_fin ? 16'(32'(r_wait)) : 16'd0;
        res.turnaround_time  = r_fin ? 16'(32'(r_turn)) : 16'd0;
        res.total_waiting    = r_sum_wait;
        res.total_turnaround = r_sum_turn;
        res.all_done         = (r_done_cnt == r_proc_cnt);
        res.now              = 16'(32'(r_time));
    end

    assign o_in_ready  = c_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_fin_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.finished |-> !o_out_item.idle)
        else $error("finished result reported as idle");

    a_drain_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DRAIN |-> r_cmp_vld && r_cmp_idx == LAST_SLOT)
        else $error("scan ended before the last slot");

    a_time_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(r_state) != ST_SERVE |-> $stable(r_time))
        else $error("time counter moved outside a served tick");

    a_sums_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_sum_wait >= $past(r_sum_wait) && r_sum_turn >= $past(r_sum_turn))
        else $error("running total decreased");

endmodule
